// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the container parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== rtl/bcp_pkg.sv =====
// Types and constants of the bytecode container parser.
package bcp_pkg;

	typedef enum logic [3:0] {
		PH_MAGIC  = 4'd0,
		PH_CCOUNT = 4'd1,
		PH_TAG    = 4'd2,
		PH_NUM    = 4'd3,
		PH_SLEN   = 4'd4,
		PH_SBYTE  = 4'd5,
		PH_BOOL   = 4'd6,
		PH_CLEN   = 4'd7,
		PH_CODE   = 4'd8,
		PH_LCOUNT = 4'd9,
		PH_LINE   = 4'd10,
		PH_DONE   = 4'd11,
		PH_ERR    = 4'd12
	} phase_t;

	typedef enum logic [2:0] {
		ST_BUSY      = 3'd0,
		ST_OK        = 3'd1,
		ST_BAD_MAGIC = 3'd2,
		ST_TRUNC     = 3'd3,
		ST_BAD_TAG   = 3'd4,
		ST_MISMATCH  = 3'd5,
		ST_TRAILING  = 3'd6
	} status_t;

	localparam logic [3:0] ROLE_IGNORED = 4'd11;

	localparam logic [7:0] TAG_NONE = 8'd0;
	localparam logic [7:0] TAG_NUM  = 8'd1;
	localparam logic [7:0] TAG_STR  = 8'd2;
	localparam logic [7:0] TAG_BOOL = 8'd3;

	localparam logic [31:0] NUM_BYTES = 32'd8;

	localparam logic [7:0] MAGIC_BYTES [4] = '{8'h4F, 8'h42, 8'h43, 8'h31};

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} bcp_in_t;

	typedef struct packed {
		logic [3:0]  byte_role;
		logic [31:0] field_value;
		logic        field_complete;
		logic [2:0]  status;
	} bcp_out_t;

	typedef struct packed {
		phase_t      parse_phase;
		logic [1:0]  byte_in_field;
		logic [31:0] field_accumulator;
		logic [31:0] items_left;
		logic [31:0] bytes_left;
		logic [31:0] code_length;
		logic        count_mismatch;
		status_t     sticky_error;
	} bcp_state_t;

	localparam bcp_state_t STATE_RESET = '{
		parse_phase:       PH_MAGIC,
		byte_in_field:     2'd0,
		field_accumulator: 32'd0,
		items_left:        32'd0,
		bytes_left:        32'd0,
		code_length:       32'd0,
		count_mismatch:    1'b0,
		sticky_error:      ST_BUSY
	};

endpackage

// ===== rtl/bytecode_container_parser_top.sv =====
// Bytecode container parser: input register, parse step, result register.
//
// Usage: bytes of a container file enter on the byte channel (valid/ready),
// with last_byte set on the final byte. Every byte yields exactly one result
// on the result channel: the byte's role in the file, the completed 32-bit
// little-endian field value (or the byte itself), a field-complete flag and
// the parse status. Errors are sticky until the final byte of the file.
// A byte taken from the byte channel is held in the input register, parsed
// from there, and its result is loaded into the result register.
// Throughput: one byte per cycle unless stalled; the parser state update
// is one pass of compare and 32-bit decrement logic between the registers.
// Reset (arst_n low) empties both stages and puts the parser at the first
// magic byte. After the final byte the parser state clears by itself.
// If the receiver stalls, the result waits in its register, the input stage
// holds one more byte, and byte_ready drops until the result transfers.
module bytecode_container_parser_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	output logic              byte_ready,
	input  bcp_pkg::bcp_in_t  byte_item,
	output logic              result_valid,
	input  logic              result_ready,
	output bcp_pkg::bcp_out_t result_item
);
	import bcp_pkg::*;

	`include "assert_macros.svh"

	bcp_in_t    item_s1;
	logic       valid_s1;
	bcp_out_t   res_s2;
	logic       valid_s2;
	bcp_state_t state_q;
	bcp_state_t state_next;
	bcp_out_t   step_res;
	logic       advance;
	logic       in_word_field;

	assign advance    = valid_s1 && (!valid_s2 || result_ready);
	assign byte_ready = !valid_s1 || advance;

	bcp_step u_step (
		.state      (state_q),
		.item       (item_s1),
		.next_state (state_next),
		.result     (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= STATE_RESET;
		end else begin
			if (byte_ready) valid_s1 <= byte_valid;
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_next;
			end else if (result_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) item_s1 <= byte_item;
		if (advance) res_s2 <= step_res;
	end

	assign result_valid = valid_s2;
	assign result_item  = res_s2;

	// phases that may hold a partly assembled 4-byte field
	assign in_word_field = (state_q.parse_phase == PH_MAGIC) ||
		(state_q.parse_phase == PH_CCOUNT) || (state_q.parse_phase == PH_SLEN) ||
		(state_q.parse_phase == PH_CLEN) || (state_q.parse_phase == PH_LCOUNT) ||
		(state_q.parse_phase == PH_LINE) || (state_q.parse_phase == PH_ERR);

	`ASSERT_NEVER(a_ignored_not_complete, clk, arst_n,
		result_valid && result_item.byte_role == ROLE_IGNORED && result_item.field_complete)
	`ASSERT_ALWAYS(a_last_clears, clk, arst_n,
		advance && item_s1.last_byte |=>
		state_q.parse_phase == PH_MAGIC && state_q.sticky_error == ST_BUSY)
	`ASSERT_ALWAYS(a_error_phase, clk, arst_n,
		state_q.sticky_error != ST_BUSY |-> state_q.parse_phase == PH_ERR)
	`ASSERT_ALWAYS(a_partial_word_phase, clk, arst_n,
		state_q.byte_in_field != 2'd0 |-> in_word_field)

endmodule

// ===== rtl/bcp_step.sv =====
// Per-byte parse step: next parser state and the result for one byte.
module bcp_step (
	input  bcp_pkg::bcp_state_t state,
	input  bcp_pkg::bcp_in_t    item,
	output bcp_pkg::bcp_state_t next_state,
	output bcp_pkg::bcp_out_t   result
);
	import bcp_pkg::*;

	bcp_state_t  upd;
	logic [7:0]  b;
	logic [31:0] shifted;
	logic [31:0] wval;
	logic        word_done;
	logic        magic_ok;
	logic        word_phase;
	logic [31:0] items_dec;
	logic [31:0] bytes_dec;
	logic        mis_now;

	assign b         = item.data_byte;
	assign shifted   = {24'd0, b} << {state.byte_in_field, 3'b000};
	assign wval      = state.field_accumulator | shifted;
	assign word_done = (state.byte_in_field == 2'd3);
	assign magic_ok  = (b == MAGIC_BYTES[state.byte_in_field]);
	assign items_dec = state.items_left - 32'd1;
	assign bytes_dec = state.bytes_left - 32'd1;
	assign mis_now   = (wval != state.code_length);

	// next state
	always_comb begin
		upd = state;
		if (state.sticky_error == ST_BUSY) begin
			case (state.parse_phase)
				PH_MAGIC: begin
					if (!magic_ok) begin
						upd.sticky_error = ST_BAD_MAGIC;
					end else begin
						upd.field_accumulator = word_done ? 32'd0 : wval;
						upd.byte_in_field = state.byte_in_field + 2'd1;
						if (word_done) upd.parse_phase = PH_CCOUNT;
					end
				end
				PH_CCOUNT: begin
					upd.field_accumulator = word_done ? 32'd0 : wval;
					upd.byte_in_field = state.byte_in_field + 2'd1;
					if (word_done) begin
						upd.items_left = wval;
						upd.parse_phase = (wval != 32'd0) ? PH_TAG : PH_CLEN;
					end
				end
				PH_TAG: begin
					case (b)
						TAG_NONE: begin
							upd.items_left = items_dec;
							upd.parse_phase = (items_dec != 32'd0) ? PH_TAG : PH_CLEN;
						end
						TAG_NUM: begin
							upd.bytes_left = NUM_BYTES;
							upd.parse_phase = PH_NUM;
						end
						TAG_STR:  upd.parse_phase = PH_SLEN;
						TAG_BOOL: upd.parse_phase = PH_BOOL;
						default:  upd.sticky_error = ST_BAD_TAG;
					endcase
				end
				PH_NUM, PH_SBYTE: begin
					upd.bytes_left = bytes_dec;
					if (bytes_dec == 32'd0) begin
						upd.items_left = items_dec;
						upd.parse_phase = (items_dec != 32'd0) ? PH_TAG : PH_CLEN;
					end
				end
				PH_SLEN: begin
					upd.field_accumulator = word_done ? 32'd0 : wval;
					upd.byte_in_field = state.byte_in_field + 2'd1;
					if (word_done) begin
						if (wval == 32'd0) begin
							upd.items_left = items_dec;
							upd.parse_phase = (items_dec != 32'd0) ? PH_TAG : PH_CLEN;
						end else begin
							upd.bytes_left = wval;
							upd.parse_phase = PH_SBYTE;
						end
					end
				end
				PH_BOOL: begin
					upd.items_left = items_dec;
					upd.parse_phase = (items_dec != 32'd0) ? PH_TAG : PH_CLEN;
				end
				PH_CLEN: begin
					upd.field_accumulator = word_done ? 32'd0 : wval;
					upd.byte_in_field = state.byte_in_field + 2'd1;
					if (word_done) begin
						upd.code_length = wval;
						upd.bytes_left = wval;
						upd.parse_phase = (wval != 32'd0) ? PH_CODE : PH_LCOUNT;
					end
				end
				PH_CODE: begin
					upd.bytes_left = bytes_dec;
					if (bytes_dec == 32'd0) upd.parse_phase = PH_LCOUNT;
				end
				PH_LCOUNT: begin
					upd.field_accumulator = word_done ? 32'd0 : wval;
					upd.byte_in_field = state.byte_in_field + 2'd1;
					if (word_done) begin
						upd.count_mismatch = mis_now;
						upd.items_left = wval;
						if (wval != 32'd0) begin
							upd.parse_phase = PH_LINE;
						end else if (mis_now) begin
							upd.sticky_error = ST_MISMATCH;
						end else begin
							upd.parse_phase = PH_DONE;
						end
					end
				end
				PH_LINE: begin
					upd.field_accumulator = word_done ? 32'd0 : wval;
					upd.byte_in_field = state.byte_in_field + 2'd1;
					if (word_done) begin
						upd.items_left = items_dec;
						if (items_dec == 32'd0) begin
							if (state.count_mismatch) upd.sticky_error = ST_MISMATCH;
							else upd.parse_phase = PH_DONE;
						end
					end
				end
				PH_DONE: upd.sticky_error = ST_TRAILING;
				default: ;
			endcase
			if (upd.sticky_error != ST_BUSY) upd.parse_phase = PH_ERR;
		end
	end

	assign next_state = item.last_byte ? STATE_RESET : upd;

	// result
	always_comb begin
		word_phase = 1'b0;
		result.byte_role = ROLE_IGNORED;
		result.field_complete = 1'b0;
		if (state.sticky_error == ST_BUSY) begin
			case (state.parse_phase)
				PH_MAGIC: begin
					result.byte_role = 4'(state.parse_phase);
					word_phase = magic_ok;
					result.field_complete = magic_ok && word_done;
				end
				PH_CCOUNT, PH_SLEN, PH_CLEN, PH_LCOUNT, PH_LINE: begin
					result.byte_role = 4'(state.parse_phase);
					word_phase = 1'b1;
					result.field_complete = word_done;
				end
				PH_TAG, PH_SBYTE, PH_BOOL, PH_CODE: begin
					result.byte_role = 4'(state.parse_phase);
					result.field_complete = 1'b1;
				end
				PH_NUM: begin
					result.byte_role = 4'(state.parse_phase);
					result.field_complete = (bytes_dec == 32'd0);
				end
				default: ;
			endcase
		end
		result.field_value = (word_phase && word_done) ? wval : {24'd0, b};

		if (upd.sticky_error != ST_BUSY)
			result.status = upd.sticky_error;
		else if (item.last_byte && upd.parse_phase == PH_MAGIC)
			result.status = ST_BAD_MAGIC;
		else if (item.last_byte)
			result.status = (upd.parse_phase == PH_DONE) ? ST_OK : ST_TRUNC;
		else
			result.status = ST_BUSY;
	end

endmodule

// ===== tb/bcp_tb_pkg.sv =====
// Expected-result predictor and result checker for the container parser testbench.
package bcp_tb_pkg;
	import bcp_pkg::*;

	typedef enum logic [3:0] {
		R_MAGIC  = 4'd0,
		R_CCOUNT = 4'd1,
		R_TAG    = 4'd2,
		R_NUM    = 4'd3,
		R_SLEN   = 4'd4,
		R_SBYTE  = 4'd5,
		R_BOOL   = 4'd6,
		R_CLEN   = 4'd7,
		R_CODE   = 4'd8,
		R_LCOUNT = 4'd9,
		R_LINE   = 4'd10
	} role_t;

	class container_checker;
		bcp_out_t    expected_reports[$];
		int          fail_count;

		phase_t      phase;
		logic [1:0]  word_pos;
		logic [31:0] word_acc;
		logic [31:0] word_val;
		logic [31:0] count_left;
		logic [31:0] run_left;
		logic [31:0] code_len;
		bit          counts_differ;
		status_t     err;

		function new();
			fail_count = 0;
			clear_parse();
		endfunction

		function void clear_parse();
			phase = PH_MAGIC;
			word_pos = 2'd0;
			word_acc = '0;
			word_val = '0;
			count_left = '0;
			run_left = '0;
			code_len = '0;
			counts_differ = 1'b0;
			err = ST_BUSY;
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("MISMATCH %s: got 0x%0h, want 0x%0h", what, got, want);
			fail_count++;
		endtask

		// little-endian 4-byte field; word_val holds the value when it completes
		function bit take_word(logic [7:0] b);
			word_acc = word_acc | ({24'd0, b} << (8 * word_pos));
			if (word_pos == 2'd3) begin
				word_val = word_acc;
				word_acc = '0;
				word_pos = 2'd0;
				return 1'b1;
			end
			word_pos = word_pos + 2'd1;
			return 1'b0;
		endfunction

		function void constant_done();
			count_left = count_left - 32'd1;
			if (count_left != 0)
				phase = PH_TAG;
			else
				phase = PH_CLEN;
		endfunction

		function void lines_done();
			if (counts_differ)
				err = ST_MISMATCH;
			else
				phase = PH_DONE;
		endfunction

		function void note_byte(bcp_in_t it);
			logic [7:0]  b;
			logic [3:0]  role;
			logic [31:0] val;
			logic        comp;
			status_t     st;
			bcp_out_t    e;
			b = it.data_byte;
			role = ROLE_IGNORED;
			val = {24'd0, b};
			comp = 1'b0;
			if (err == ST_BUSY) begin
				case (phase)
					PH_MAGIC: begin
						role = R_MAGIC;
						if (b != MAGIC_BYTES[word_pos]) begin
							err = ST_BAD_MAGIC;
						end else if (take_word(b)) begin
							val = word_val;
							comp = 1'b1;
							phase = PH_CCOUNT;
						end
					end
					PH_CCOUNT: begin
						role = R_CCOUNT;
						if (take_word(b)) begin
							val = word_val;
							comp = 1'b1;
							count_left = word_val;
							if (word_val != 0)
								phase = PH_TAG;
							else
								phase = PH_CLEN;
						end
					end
					PH_TAG: begin
						role = R_TAG;
						comp = 1'b1;
						case (b)
							TAG_NONE: constant_done();
							TAG_NUM: begin
								run_left = NUM_BYTES;
								phase = PH_NUM;
							end
							TAG_STR: phase = PH_SLEN;
							TAG_BOOL: phase = PH_BOOL;
							default: err = ST_BAD_TAG;
						endcase
					end
					PH_NUM: begin
						role = R_NUM;
						run_left = run_left - 32'd1;
						if (run_left == 0) begin
							comp = 1'b1;
							constant_done();
						end
					end
					PH_SLEN: begin
						role = R_SLEN;
						if (take_word(b)) begin
							val = word_val;
							comp = 1'b1;
							if (word_val == 0) begin
								constant_done();
							end else begin
								run_left = word_val;
								phase = PH_SBYTE;
							end
						end
					end
					PH_SBYTE: begin
						role = R_SBYTE;
						comp = 1'b1;
						run_left = run_left - 32'd1;
						if (run_left == 0)
							constant_done();
					end
					PH_BOOL: begin
						role = R_BOOL;
						comp = 1'b1;
						constant_done();
					end
					PH_CLEN: begin
						role = R_CLEN;
						if (take_word(b)) begin
							val = word_val;
							comp = 1'b1;
							code_len = word_val;
							run_left = word_val;
							if (word_val != 0)
								phase = PH_CODE;
							else
								phase = PH_LCOUNT;
						end
					end
					PH_CODE: begin
						role = R_CODE;
						comp = 1'b1;
						run_left = run_left - 32'd1;
						if (run_left == 0)
							phase = PH_LCOUNT;
					end
					PH_LCOUNT: begin
						role = R_LCOUNT;
						if (take_word(b)) begin
							val = word_val;
							comp = 1'b1;
							counts_differ = (word_val != code_len);
							count_left = word_val;
							if (word_val == 0)
								lines_done();
							else
								phase = PH_LINE;
						end
					end
					PH_LINE: begin
						role = R_LINE;
						if (take_word(b)) begin
							val = word_val;
							comp = 1'b1;
							count_left = count_left - 32'd1;
							if (count_left == 0)
								lines_done();
						end
					end
					PH_DONE: err = ST_TRAILING;
					default: ;
				endcase
				if (err != ST_BUSY)
					phase = PH_ERR;
			end

			if (err != ST_BUSY)
				st = err;
			else if (it.last_byte && phase == PH_MAGIC)
				st = ST_BAD_MAGIC;
			else if (it.last_byte && phase == PH_DONE)
				st = ST_OK;
			else if (it.last_byte)
				st = ST_TRUNC;
			else
				st = ST_BUSY;

			e.byte_role = role;
			e.field_value = val;
			e.field_complete = comp;
			e.status = st;
			expected_reports = {expected_reports, e};

			if (it.last_byte)
				clear_parse();
		endfunction

		task check_report(bcp_out_t got);
			bcp_out_t e;
			if (expected_reports.size() == 0) begin
				report("result with nothing pending", {28'd0, got.byte_role}, 32'd0);
				return;
			end
			e = expected_reports.pop_front();
			if (got.byte_role != e.byte_role)
				report("byte_role", {28'd0, got.byte_role}, {28'd0, e.byte_role});
			if (got.field_value != e.field_value)
				report("field_value", got.field_value, e.field_value);
			if (got.field_complete != e.field_complete)
				report("field_complete", {31'd0, got.field_complete},
					{31'd0, e.field_complete});
			if (got.status != e.status)
				report("status", {29'd0, got.status}, {29'd0, e.status});
		endtask
	endclass

endpackage

// ===== tb/bytecode_container_parser_top_tb.sv =====
// Top-level testbench of the bytecode container parser: clock, reset, stimulus, checking.
module bytecode_container_parser_top_tb;
	import bcp_pkg::*;
	import bcp_tb_pkg::*;

	localparam int CYCLE_LIMIT = 800000;
	localparam int RANDOM_BYTES = 800;

	logic     clk;
	logic     arst_n = 1'b0;
	logic     byte_valid = 1'b0;
	logic     byte_ready;
	bcp_in_t  byte_item = '0;
	logic     result_valid;
	logic     result_ready = 1'b0;
	bcp_out_t result_item;

	container_checker checker_h;
	logic [7:0]       file_bytes[$];
	int               sent_count = 0;
	int               cycle_count = 0;
	int               stall_left = 0;
	bit               no_idle = 1'b0;

	bytecode_container_parser_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.byte_item    (byte_item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_item  (result_item)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// mostly short waits, now and then a long one
	function automatic int pick_wait();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic int pick_gap();
		if (no_idle || $urandom_range(0, 99) < 65)
			return 0;
		return pick_wait();
	endfunction

	// result side: check each transfer, stall at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready)
				checker_h.check_report(result_item);
			if (stall_left > 0)
				stall_left--;
			else if (!no_idle && $urandom_range(0, 3) == 0)
				stall_left = pick_wait();
			result_ready <= (stall_left == 0);
		end
	end

	function automatic void put_b(logic [7:0] b);
		file_bytes = {file_bytes, b};
	endfunction

	function automatic void put_w(logic [31:0] w);
		for (int i = 0; i < 4; i++)
			file_bytes = {file_bytes, w[8*i +: 8]};
	endfunction

	function automatic void put_magic();
		for (int i = 0; i < 4; i++)
			file_bytes = {file_bytes, MAGIC_BYTES[i]};
	endfunction

	function automatic void cut_to(int n);
		while (file_bytes.size() > n)
			void'(file_bytes.pop_back());
	endfunction

	// well-formed file with random content; optional bad tag or line count mismatch
	function automatic void build_file(bit bad_tag, bit mismatch);
		int         n;
		int         bad_at;
		int         slen;
		int         clen;
		int         lc;
		logic [7:0] tag;
		file_bytes.delete();
		put_magic();
		n = $urandom_range(0, 4);
		if (bad_tag && n == 0)
			n = 1;
		bad_at = (n > 0) ? $urandom_range(0, n - 1) : 0;
		put_w(n);
		for (int i = 0; i < n; i++) begin
			if (bad_tag && i == bad_at)
				tag = 8'($urandom_range(4, 255));
			else
				tag = 8'($urandom_range(0, 3));
			put_b(tag);
			case (tag)
				TAG_NUM: for (int k = 0; k < 8; k++) put_b(8'($urandom_range(0, 255)));
				TAG_STR: begin
					slen = $urandom_range(0, 6);
					put_w(slen);
					for (int k = 0; k < slen; k++)
						put_b(8'($urandom_range(0, 255)));
				end
				TAG_BOOL: put_b(8'($urandom_range(0, 255)));
				default: ;
			endcase
		end
		clen = $urandom_range(0, 8);
		put_w(clen);
		for (int k = 0; k < clen; k++)
			put_b(8'($urandom_range(0, 255)));
		lc = clen;
		if (mismatch) begin
			do
				lc = $urandom_range(0, 9);
			while (lc == clen);
		end
		put_w(lc);
		for (int k = 0; k < lc; k++)
			put_w($urandom);
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic lst);
		bcp_in_t it;
		int      gap;
		it.data_byte = b;
		it.last_byte = lst;
		gap = pick_gap();
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_item <= it;
		byte_valid <= 1'b1;
		do
			@(posedge clk);
		while (!byte_ready);
		checker_h.note_byte(it);
		sent_count++;
	endtask

	task automatic send_file();
		for (int i = 0; i < file_bytes.size(); i++)
			send_byte(file_bytes[i], i == file_bytes.size() - 1);
		file_bytes.delete();
	endtask

	initial begin
		int kind;
		int n;
		checker_h = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// smallest complete file
		put_magic(); put_w(0); put_w(0); put_w(0); send_file();
		// every tag, number bytes at both extremes
		put_magic(); put_w(4);
		put_b(TAG_NONE);
		put_b(TAG_NUM);
		put_b(8'h00); put_b(8'hFF); put_b(8'h00); put_b(8'hFF);
		put_b(8'h80); put_b(8'h7F); put_b(8'h01); put_b(8'hFE);
		put_b(TAG_STR); put_w(2); put_b(8'h68); put_b(8'h69);
		put_b(TAG_BOOL); put_b(8'h01);
		put_w(1); put_b(8'hFF); put_w(1); put_w(32'hFFFF_FFFF);
		send_file();
		// empty string constant
		put_magic(); put_w(1); put_b(TAG_STR); put_w(0); put_w(0); put_w(0); send_file();
		// wrong magic byte, then a byte after the error
		put_b(8'h58); put_b(8'h42); send_file();
		// file ends inside the magic
		put_b(MAGIC_BYTES[0]); send_file();
		put_b(MAGIC_BYTES[0]); put_b(MAGIC_BYTES[1]); send_file();
		// file ends right after the magic
		put_magic(); send_file();
		// unknown tag, followed by ignored bytes
		put_magic(); put_w(1); put_b(8'hFF); put_b(8'h00); send_file();
		// zero line count against a nonzero code length
		put_magic(); put_w(0); put_w(1); put_b(8'h00); put_w(0); send_file();
		// mismatch found at the end of the line table
		put_magic(); put_w(0); put_w(0); put_w(1); put_w(0); send_file();
		// bytes past a complete file
		put_magic(); put_w(0); put_w(0); put_w(0); put_b(8'h00); put_b(8'hFF); send_file();
		// huge constant count and huge string length, both truncated
		put_magic(); put_w(32'hFFFF_FFFF); put_b(TAG_NONE); put_b(TAG_BOOL); put_b(8'h00);
		send_file();
		put_magic(); put_w(1); put_b(TAG_STR); put_w(32'hFFFF_FFFF); put_b(8'h55); send_file();

		while (sent_count < RANDOM_BYTES) begin
			no_idle = ($urandom_range(0, 4) == 0);
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				build_file(1'b0, 1'b0);
			end else if (kind < 48) begin
				build_file(1'b0, 1'b0);
				n = $urandom_range(0, 3);
				file_bytes[n] = file_bytes[n] ^ 8'($urandom_range(1, 255));
			end else if (kind < 53) begin
				build_file(1'b0, 1'b0);
				cut_to($urandom_range(1, 4));
			end else if (kind < 63) begin
				build_file(1'b0, 1'b0);
				cut_to($urandom_range(5, file_bytes.size() - 1));
			end else if (kind < 71) begin
				build_file(1'b1, 1'b0);
			end else if (kind < 81) begin
				build_file(1'b0, 1'b1);
			end else if (kind < 89) begin
				build_file(1'b0, 1'b0);
				n = $urandom_range(1, 4);
				for (int k = 0; k < n; k++)
					put_b(8'($urandom_range(0, 255)));
			end else begin
				// noise, half of it behind a valid magic
				file_bytes.delete();
				if ($urandom_range(0, 1))
					put_magic();
				n = $urandom_range(1, 20);
				for (int k = 0; k < n; k++)
					put_b(8'($urandom_range(0, 255)));
			end
			send_file();
		end
		byte_valid <= 1'b0;
		no_idle = 1'b0;

		while (checker_h.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (checker_h.fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
